### hdl/locked_expansion_ram_with_header_assert.svh
// Assertion macros used by the checker of the expansion RAM block.
`ifndef LOCKED_EXPANSION_RAM_WITH_HEADER_ASSERT_SVH
`define LOCKED_EXPANSION_RAM_WITH_HEADER_ASSERT_SVH

// Clocked property, switched off while reset is low.
`define LERH_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define LERH_ASSERT_IMPLIES(label, ante, cons, msg) \
    `LERH_ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define LERH_ASSERT_NEXT(label, ante, cons, msg) \
    `LERH_ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

### hdl/lerh_pkg.sv
// Package: types, address map and header table of the expansion RAM block.
package lerh_pkg;

    // Default size of the RAM window in bytes
    localparam int unsigned RAM_BYTES_DEF = 8388608;

    // Bus address map (28-bit byte addresses)
    localparam logic [27:0] HDR_BASE  = 28'h80000B0;
    localparam logic [27:0] HDR_END   = 28'h80000C0;
    localparam logic [27:0] RAM_BASE  = 28'h9000000;
    localparam logic [27:0] ID_ADDR   = 28'h801FFFC;
    localparam logic [27:0] ZERO_ADDR = 28'h8240002;
    localparam logic [27:0] LOCK_ADDR = 28'h8240000;

    // Fixed halfword answer at the ID address
    localparam logic [31:0] ID_VALUE = 32'h0000_7FFF;

    // Operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Access size codes; code three is taken as a word
    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } size_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_ACCESS
    } state_t;

    // Decoded access, passed from decoder to datapath
    typedef struct packed {
        size_t       sz;
        logic        hdr_hit;
        logic        id_hit;
        logic        zero_hit;
        logic        lock_hit;
        logic        ram_hit;
        logic [3:0]  byte_off;
    } lerh_dec_t;

    // Identification header, one byte per offset
    function automatic logic [7:0] hdr_byte(input logic [3:0] o);
        logic [7:0] b;
        unique case (o)
            4'h0: b = 8'hFF;
            4'h1: b = 8'hFF;
            4'h2: b = 8'h96;
            4'h3: b = 8'h00;
            4'h4: b = 8'h00;
            4'h5: b = 8'h24;
            4'h6: b = 8'h24;
            4'h7: b = 8'h24;
            4'h8: b = 8'hFF;
            4'h9: b = 8'hFF;
            4'hA: b = 8'hFF;
            4'hB: b = 8'hFF;
            4'hC: b = 8'hFF;
            4'hD: b = 8'hFF;
            4'hE: b = 8'hFF;
            4'hF: b = 8'h7F;
        endcase
        return b;
    endfunction

    // Lane mask for an access size
    function automatic logic [31:0] size_mask(input size_t sz);
        logic [31:0] m;
        unique case (sz)
            SZ_BYTE: m = 32'h0000_00FF;
            SZ_HALF: m = 32'h0000_FFFF;
            SZ_WORD: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

### hdl/lerh_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
module lerh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/lerh_decode.sv
// Address decoder: aligns the access and sorts it into header, special, RAM or open bus.
module lerh_decode #(
    parameter int unsigned RAM_BYTES = lerh_pkg::RAM_BYTES_DEF
) (
    input  logic [1:0]                              size,
    input  logic [27:0]                             address,
    output lerh_pkg::lerh_dec_t                     dec,
    output logic [$clog2((RAM_BYTES + 3) / 4)-1:0]  ram_index
);
    import lerh_pkg::*;

    localparam int unsigned RAM_WORDS = (RAM_BYTES + 3) / 4;
    localparam int unsigned IDX_W     = $clog2(RAM_WORDS);

    size_t       sz;
    logic [27:0] a;
    logic [27:0] off;

    always_comb
    begin
        // Size code three behaves as a word
        if (size == SZ_BYTE)
        begin
            sz = SZ_BYTE;
        end
        else if (size == SZ_HALF)
        begin
            sz = SZ_HALF;
        end
        else
        begin
            sz = SZ_WORD;
        end

        // Drop the address bits below the access size
        unique case (sz)
            SZ_BYTE: a = address;
            SZ_HALF: a = {address[27:1], 1'b0};
            SZ_WORD: a = {address[27:2], 2'b00};
        endcase

        off = a - RAM_BASE;

        dec.sz       = sz;
        dec.hdr_hit  = (a >= HDR_BASE) && (a < HDR_END);
        dec.id_hit   = (sz == SZ_HALF) && (a == ID_ADDR);
        dec.zero_hit = (sz == SZ_HALF) && (a == ZERO_ADDR);
        dec.lock_hit = (sz == SZ_HALF) && (a == LOCK_ADDR);
        dec.ram_hit  = (a >= RAM_BASE) && (off < 28'(RAM_BYTES));
        dec.byte_off = a[3:0];

        // Word index inside the window; only meaningful on a RAM hit
        ram_index = off[IDX_W+1:2];
    end

endmodule

### hdl/locked_expansion_ram_with_header.sv
// Memory expansion device for a cartridge slot. Each input word is one bus access
// (read or write; byte, halfword or word; aligned down to its size) and gives exactly
// one output word: the read value zero-extended, or zero for a write. Reads see a
// fixed 16-byte identification header, two special halfword addresses, the
// little-endian RAM window at 0x9000000, or all ones. A halfword write to 0x8240000
// sets the write lock to the inverse of data bit 0; the lock comes out of reset set,
// and other writes reach the RAM only while it is clear. In ST_IDLE a word is taken
// and read from the single RAM; in ST_ACCESS it is merged, written back and registered
// out, so a new word is taken only after the last one has left ST_ACCESS. The output
// register lets the next access be taken while a result waits; a full output register
// holds the access in ST_ACCESS. RAM contents are undefined until written.
module locked_expansion_ram_with_header #(
    parameter int unsigned RAM_BYTES = lerh_pkg::RAM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [1:0]  size,
    input  logic [27:0] address,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data
);
    import lerh_pkg::*;

    localparam int unsigned RAM_WORDS = (RAM_BYTES + 3) / 4;
    localparam int unsigned IDX_W     = $clog2(RAM_WORDS);

    // Control state
    state_t      state_reg, state_next;
    logic        locked_reg, locked_next;
    logic        out_valid_reg, out_valid_next;

    // Payload held for the access in flight
    logic        op_reg;
    lerh_dec_t   dec_reg;
    logic [IDX_W-1:0] index_reg;
    logic [31:0] wdata_reg;
    logic [31:0] read_data_reg, read_data_next;

    // Decoder and RAM wiring
    lerh_dec_t   dec_in;
    logic [IDX_W-1:0] index_in;
    logic        accept;
    logic        advance;
    logic        ram_we;
    logic [31:0] ram_rdata;
    logic [31:0] ram_wdata;

    // Datapath intermediates
    logic [4:0]  shamt;
    logic [31:0] mask;
    logic [31:0] wmask;
    logic [31:0] hdr_val;
    logic [31:0] rd_val;

    lerh_decode #(
        .RAM_BYTES (RAM_BYTES)
    ) u_decode (
        .size      (size),
        .address   (address),
        .dec       (dec_in),
        .ram_index (index_in)
    );

    lerh_ram #(
        .WIDTH (32),
        .DEPTH (RAM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (index_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (index_in),
        .rdata (ram_rdata)
    );

    // Read value selection and write merge
    always_comb
    begin
        shamt   = {dec_reg.byte_off[1:0], 3'b000};
        mask    = size_mask(dec_reg.sz);
        wmask   = mask << shamt;
        hdr_val = {hdr_byte(4'(dec_reg.byte_off + 4'd3)),
                   hdr_byte(4'(dec_reg.byte_off + 4'd2)),
                   hdr_byte(4'(dec_reg.byte_off + 4'd1)),
                   hdr_byte(dec_reg.byte_off)};

        priority if (dec_reg.hdr_hit)
        begin
            rd_val = hdr_val & mask;
        end
        else if (dec_reg.id_hit)
        begin
            rd_val = ID_VALUE;
        end
        else if (dec_reg.zero_hit)
        begin
            rd_val = '0;
        end
        else if (dec_reg.ram_hit)
        begin
            rd_val = (ram_rdata >> shamt) & mask;
        end
        else
        begin
            rd_val = mask;
        end

        ram_wdata = (ram_rdata & ~wmask) | ((wdata_reg << shamt) & wmask);
    end

    // Sequencer: next state and handshakes
    always_comb
    begin
        state_next     = state_reg;
        locked_next    = locked_reg;
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        in_ready       = 1'b0;
        accept         = 1'b0;
        advance        = 1'b0;
        ram_we         = 1'b0;

        // Output word leaves
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                accept   = in_valid;
                if (in_valid)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                advance = !out_valid_reg || out_ready;
                if (advance)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    read_data_next = (op_reg == OP_WRITE) ? '0 : rd_val;
                    if (op_reg == OP_WRITE)
                    begin
                        if (dec_reg.lock_hit)
                        begin
                            locked_next = ~wdata_reg[0];
                        end
                        else
                        begin
                            ram_we = !locked_reg && dec_reg.ram_hit;
                        end
                    end
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            locked_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            locked_reg    <= locked_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            dec_reg   <= dec_in;
            index_reg <= index_in;
            wdata_reg <= write_data;
        end
        read_data_reg <= read_data_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule

### hdl/lerh_checker.sv
// Port checker for the expansion RAM block, bound to the top level.
`include "locked_expansion_ram_with_header_assert.svh"

module lerh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        op,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] read_data
);
    import lerh_pkg::*;

    // Handshake shorthands
    logic in_take;
    logic out_stall;
    logic wr_take;
    logic zero_out;

    assign in_take   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;
    assign wr_take   = in_take && (op == OP_WRITE) && (!out_valid || out_ready);
    assign zero_out  = out_valid && (read_data == 32'h0);

    // A stalled output word holds
    `LERH_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(read_data), "stalled word moved")

    // One access at a time: no word taken in the cycle after an accept
    `LERH_ASSERT_NEXT(a_one_in_flight, in_take, !in_ready, "word taken during an access")

    // A write taken while the output side is free answers zero, with no stall in ST_ACCESS
    `LERH_ASSERT_NEXT(a_write_zero, wr_take, ##1 zero_out, "write did not answer zero on time")

    // A result only appears after the access cycle
    `LERH_ASSERT_IMPLIES(a_out_rise, $rose(out_valid), $past(!in_ready), "output without access")

endmodule

bind locked_expansion_ram_with_header lerh_checker u_lerh_checker (.*);

### tb/locked_expansion_ram_with_header_tb.sv
// Self-checking testbench for the locked expansion RAM with identification header.
`timescale 1ns / 1ps

module locked_expansion_ram_with_header_tb;

    import lerh_pkg::*;

    localparam int unsigned WINDOW_BYTES = RAM_BYTES_DEF;
    localparam logic [27:0] RAM_LAST     = 28'(RAM_BASE + WINDOW_BYTES - 1);
    localparam logic [27:0] RAM_TOP      = 28'(RAM_BASE + WINDOW_BYTES);
    localparam logic [1:0]  SZ_CODE3     = 2'd3;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          CYCLE_LIMIT  = 200000;

    // Bus access predictor and queue of read_data words still due
    class ram_scoreboard;
        bit          locked;
        bit [7:0]    id_header [16];
        bit [7:0]    ram_bytes [int unsigned];
        int unsigned written_offs [$];
        logic [31:0] read_data_due [$];
        int          errors;

        function new();
            locked    = 1'b1;
            errors    = 0;
            id_header = '{8'hFF, 8'hFF, 8'h96, 8'h00, 8'h00, 8'h24, 8'h24, 8'h24,
                          8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        endfunction

        // Size code three is a word; low address bits below the size are dropped
        function void normalise(input logic [1:0] raw_size, input logic [27:0] raw_addr,
                                output logic [1:0] sz, output logic [27:0] a,
                                output int n);
            sz = (raw_size == SZ_CODE3) ? SZ_WORD : raw_size;
            a  = raw_addr;
            if (sz == SZ_HALF)
                a[0] = 1'b0;
            else if (sz == SZ_WORD)
                a[1:0] = 2'b00;
            n = (sz == SZ_BYTE) ? 1 : (sz == SZ_HALF) ? 2 : 4;
        endfunction

        function bit in_window(input logic [27:0] a, output int unsigned off);
            off = 32'(a) - 32'(RAM_BASE);
            return (a >= RAM_BASE) && (off < WINDOW_BYTES);
        endfunction

        // True unless the access would read RAM bytes never written
        function bit read_defined(input logic [1:0] raw_size, input logic [27:0] raw_addr);
            logic [1:0]  sz;
            logic [27:0] a;
            int          n;
            int unsigned off;
            normalise(raw_size, raw_addr, sz, a, n);
            if (!in_window(a, off))
                return 1'b1;
            for (int i = 0; i < n; i++)
                if (!ram_bytes.exists(off + i))
                    return 1'b0;
            return 1'b1;
        endfunction

        function logic [31:0] bus_read_value(input logic [1:0] sz, input logic [27:0] a,
                                             input int n);
            logic [31:0] v;
            logic [3:0]  hi;
            int unsigned off;
            v = '0;
            if (a >= HDR_BASE && a < HDR_END) begin
                for (int i = 0; i < n; i++)
                begin
                    hi = a[3:0] + 4'(i);
                    v[8*i +: 8] = id_header[hi];
                end
            end else if (sz == SZ_HALF && a == ID_ADDR) begin
                v = ID_VALUE;
            end else if (sz == SZ_HALF && a == ZERO_ADDR) begin
                v = '0;
            end else if (in_window(a, off)) begin
                for (int i = 0; i < n; i++)
                    v[8*i +: 8] = ram_bytes[off + i];
            end else begin
                for (int i = 0; i < n; i++)
                    v[8*i +: 8] = 8'hFF;
            end
            return v;
        endfunction

        // Called for every word taken on the input side
        function void note_access(input logic o, input logic [1:0] raw_size,
                                  input logic [27:0] raw_addr, input logic [31:0] d);
            logic [1:0]  sz;
            logic [27:0] a;
            int          n;
            int unsigned off;
            normalise(raw_size, raw_addr, sz, a, n);
            if (o == OP_WRITE) begin
                if (sz == SZ_HALF && a == LOCK_ADDR) begin
                    locked = ~d[0];
                end else if (!locked && in_window(a, off)) begin
                    for (int i = 0; i < n; i++)
                        ram_bytes[off + i] = d[8*i +: 8];
                    written_offs.push_back(off);
                    if (written_offs.size() > 2048)
                        void'(written_offs.pop_front());
                end
                read_data_due.push_back('0);
            end else begin
                read_data_due.push_back(bus_read_value(sz, a, n));
            end
        endfunction

        // Called for every word taken on the output side
        function void check_result(input logic [31:0] actual);
            logic [31:0] want;
            if (read_data_due.size() == 0) begin
                $display("%0t: read_data %h arrived with nothing due", $time, actual);
                errors++;
            end else begin
                want = read_data_due.pop_front();
                if (actual !== want) begin
                    $display("%0t: read_data mismatch: expected %h, actual %h",
                             $time, want, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return read_data_due.size();
        endfunction
    endclass

    bit          clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = OP_READ;
    logic [1:0]  size = SZ_BYTE;
    logic [27:0] address = '0;
    logic [31:0] write_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] read_data;

    ram_scoreboard sb = new();
    bit            idling_on = 1'b0;
    bit            rx_hold_req = 1'b0;
    int            cycle_count = 0;

    locked_expansion_ram_with_header #(
        .RAM_BYTES (WINDOW_BYTES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .size       (size),
        .address    (address),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("locked_expansion_ram_with_header_tb: done, errors");
            $finish;
        end
    end

    // Result check on pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(read_data);
    end

    // Output side: random stalls, plus one long hold when asked
    initial
    begin : result_ready
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one word and hold it until taken
    task automatic send_access(input logic o, input logic [1:0] s, input logic [27:0] a,
                               input logic [31:0] d);
        in_valid   <= 1'b1;
        op         <= o;
        size       <= s;
        address    <= a;
        write_data <= d;
        do @(posedge clk); while (!in_ready);
        sb.note_access(o, s, a, d);
    endtask

    // Stop offering until every due word is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly RAM writes and read-backs under an open lock, with some noise
    function automatic void pick_access(output logic o, output logic [1:0] s,
                                        output logic [27:0] a, output logic [31:0] d);
        int unsigned roll;
        int unsigned off;
        logic [31:0] rnd;
        roll = $urandom_range(0, 99);
        rnd  = $urandom;
        o    = OP_READ;
        s    = 2'($urandom_range(0, 3));
        a    = rnd[27:0];
        d    = $urandom;
        if (roll < 35) begin
            // RAM write, mostly near the window ends so reads find it
            o = OP_WRITE;
            case ($urandom_range(0, 4))
                0, 1, 2: off = $urandom_range(0, 255);
                3:       off = WINDOW_BYTES - 1 - $urandom_range(0, 255);
                default: off = $urandom_range(0, WINDOW_BYTES - 1);
            endcase
            a = 28'(RAM_BASE + off);
        end else if (roll < 70 && sb.written_offs.size() != 0) begin
            // read back somewhere already written
            off = sb.written_offs[$urandom_range(0, sb.written_offs.size() - 1)];
            a = 28'(RAM_BASE + off + $urandom_range(0, 3));
            if (!sb.read_defined(s, a))
            begin
                s = SZ_BYTE;
                a = 28'(RAM_BASE + off);
            end
        end else if (roll < 76) begin
            // lock register, mostly opening the RAM
            o    = OP_WRITE;
            s    = SZ_HALF;
            a    = LOCK_ADDR | 28'(rnd[0]);
            d[0] = ($urandom_range(0, 4) != 0);
        end else if (roll < 90) begin
            // header and special halfwords, any size and direction
            o = rnd[31];
            case ($urandom_range(0, 3))
                0:       a = HDR_BASE + 28'($urandom_range(0, 15));
                1:       a = ID_ADDR | 28'(rnd[1:0]);
                2:       a = ZERO_ADDR | 28'(rnd[1:0]);
                default: a = LOCK_ADDR | 28'(rnd[1:0]);
            endcase
        end else begin
            // noise anywhere
            o = rnd[30];
        end
        if (o == OP_READ && !sb.read_defined(s, a))
            o = OP_WRITE;
    endfunction

    task automatic run_random(input int count, input bit allow_idle);
        logic        o;
        logic [1:0]  s;
        logic [27:0] a;
        logic [31:0] d;
        for (int k = 0; k < count; k++)
        begin
            if (k % 100 == 0)
                idling_on = allow_idle && ($urandom_range(0, 3) != 0);
            pick_access(o, s, a, d);
            send_access(o, s, a, d);
            if (idling_on && $urandom_range(0, 4) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
    endtask

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header, special halfwords and decode fall-through
        send_access(OP_READ,  SZ_WORD,  HDR_BASE,              32'h0);
        send_access(OP_READ,  SZ_HALF,  HDR_BASE + 28'h2,      32'hFFFF_FFFF);
        send_access(OP_READ,  SZ_BYTE,  HDR_BASE + 28'hF,      32'h0);
        send_access(OP_READ,  SZ_CODE3, HDR_BASE + 28'h5,      32'h0);
        send_access(OP_READ,  SZ_HALF,  ID_ADDR,               32'h0);
        send_access(OP_READ,  SZ_BYTE,  ID_ADDR,               32'h0);
        send_access(OP_READ,  SZ_HALF,  ZERO_ADDR + 28'h1,     32'h0);
        send_access(OP_READ,  SZ_WORD,  ZERO_ADDR,             32'h0);
        // Locked after reset; byte and word writes to the lock do nothing
        send_access(OP_WRITE, SZ_WORD,  RAM_BASE,              32'hFFFF_FFFF);
        send_access(OP_WRITE, SZ_BYTE,  LOCK_ADDR,             32'h1);
        send_access(OP_WRITE, SZ_WORD,  LOCK_ADDR,             32'h1);
        send_access(OP_WRITE, SZ_HALF,  LOCK_ADDR + 28'h1,     32'hFFFF_FFFF);
        // Window edges, unaligned and size code three
        send_access(OP_WRITE, SZ_WORD,  RAM_BASE,              32'hFFFF_FFFF);
        send_access(OP_WRITE, SZ_CODE3, RAM_LAST,              32'h0);
        send_access(OP_WRITE, SZ_BYTE,  RAM_LAST,              32'h0000_00A5);
        send_access(OP_READ,  SZ_WORD,  RAM_BASE,              32'h0);
        send_access(OP_READ,  SZ_HALF,  RAM_LAST,              32'h0);
        send_access(OP_READ,  SZ_BYTE,  RAM_LAST,              32'h0);
        send_access(OP_READ,  SZ_WORD,  RAM_TOP,               32'h0);
        send_access(OP_READ,  SZ_WORD,  RAM_BASE - 28'h1,      32'h0);
        send_access(OP_READ,  SZ_BYTE,  28'hFFF_FFFF,          32'h0);
        send_access(OP_READ,  SZ_WORD,  28'h0,                 32'h0);
        // Relock, blocked write, reopen
        send_access(OP_WRITE, SZ_HALF,  LOCK_ADDR,             32'h0);
        send_access(OP_WRITE, SZ_WORD,  RAM_BASE,              32'h1234_5678);
        send_access(OP_READ,  SZ_WORD,  RAM_BASE,              32'h0);
        send_access(OP_WRITE, SZ_HALF,  LOCK_ADDR,             32'h1);
        send_access(OP_WRITE, SZ_HALF,  ZERO_ADDR,             32'h0);
        wait_drained();

        run_random(500, 1'b1);

        // Long output hold while words keep coming, then a full drain
        idling_on   = 1'b0;
        rx_hold_req = 1'b1;
        run_random(80, 1'b0);
        wait_drained();

        run_random(420, 1'b1);

        // Closing stretch at full rate
        idling_on = 1'b0;
        run_random(200, 1'b0);
        wait_drained();
        repeat (4) @(posedge clk);

        if (sb.errors == 0)
            $display("locked_expansion_ram_with_header_tb: done, clean");
        else
            $display("locked_expansion_ram_with_header_tb: done, errors");
        $finish;
    end

endmodule
